>>> rtl/mflq_pkg.sv
// ----------------------------------------------------------------------------
// mflq_pkg
// Shared types and constants of the multi-FIFO lossy queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mflq_pkg;

   localparam int OP_WIDTH    = 2;
   localparam int INDEX_WIDTH = 2;
   localparam int WORD_WIDTH  = 32;
   localparam int STAT_WIDTH  = 2;
   localparam int OCC_WIDTH   = 4;
   localparam int LOST_WIDTH  = 32;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_INIT  = 2'd2
   } op_type;

   typedef enum logic [STAT_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_LOST  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

>>> rtl/mflq_if.sv
// ----------------------------------------------------------------------------
// mflq_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mflq_req_if
   import mflq_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    op;
   logic [INDEX_WIDTH-1:0] fifo_index;
   logic [WORD_WIDTH-1:0]  write_data;

   modport source (output valid, output op, output fifo_index, output write_data,
                   input ready);
   modport sink   (input valid, input op, input fifo_index, input write_data,
                   output ready);
endinterface

interface mflq_rsp_if
   import mflq_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] read_data;
   logic [STAT_WIDTH-1:0] status;
   logic [OCC_WIDTH-1:0]  occupancy;
   logic [LOST_WIDTH-1:0] lost_total;

   modport source (output valid, output read_data, output status, output occupancy,
                   output lost_total, input ready);
   modport sink   (input valid, input read_data, input status, input occupancy,
                   input lost_total, output ready);
endinterface

`default_nettype wire

>>> rtl/mflq_ctrl.sv
// ----------------------------------------------------------------------------
// mflq_ctrl
// Controller: accepts one request, then commits it once the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mflq_ctrl
   import mflq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire ctrl_status_type stat,
   output      ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         S_EXEC: begin
            cmd.commit = !stat.out_busy;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/mflq_dp.sv
// ----------------------------------------------------------------------------
// mflq_dp
// Datapath: per-queue pointers and counters, entry store, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mflq_dp
   import mflq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int NUM_QUEUES = 4,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   output      ctrl_status_type        stat,
   input  wire logic [OP_WIDTH-1:0]    req_op,
   input  wire logic [INDEX_WIDTH-1:0] req_fifo_index,
   input  wire logic [WORD_WIDTH-1:0]  req_write_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [WORD_WIDTH-1:0]  rsp_read_data,
   output      logic [STAT_WIDTH-1:0]  rsp_status,
   output      logic [OCC_WIDTH-1:0]   rsp_occupancy,
   output      logic [LOST_WIDTH-1:0]  rsp_lost_total
);

   localparam int PW      = $clog2(DEPTH);
   localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int ENTRIES = NUM_QUEUES * DEPTH;
   localparam int AW      = $clog2(ENTRIES);

   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   // per-queue state
   logic [PW-1:0]         head_ff [NUM_QUEUES];
   logic [PW-1:0]         tail_ff [NUM_QUEUES];
   logic [PW-1:0]         count_ff[NUM_QUEUES];
   logic [LOST_WIDTH-1:0] lost_ff [NUM_QUEUES];

   logic [DATA_WIDTH-1:0] store_mem[ENTRIES];

   // request capture
   logic [OP_WIDTH-1:0]   op_ff;
   logic [QW-1:0]         q_ff;
   logic                  in_range_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] rdata_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [WORD_WIDTH-1:0] read_data_ff;
   status_type            status_ff;
   logic [OCC_WIDTH-1:0]  occ_ff;
   logic [LOST_WIDTH-1:0] lost_total_ff;

   logic                  req_in_range;
   logic [QW-1:0]         req_q;
   logic [AW-1:0]         raddr;
   logic [AW-1:0]         waddr;

   logic [PW-1:0]         head_cur;
   logic [PW-1:0]         tail_cur;
   logic [PW-1:0]         count_cur;
   logic [LOST_WIDTH-1:0] lost_cur;
   logic [PW-1:0]         head_in;
   logic [PW-1:0]         tail_in;
   logic [PW-1:0]         count_in;
   logic [LOST_WIDTH-1:0] lost_in;
   logic [DATA_WIDTH-1:0] rd_value;
   status_type            status_in;
   logic                  mem_we;
   logic                  update;

   assign req_in_range = 32'(req_fifo_index) < 32'(NUM_QUEUES);
   assign req_q        = req_in_range ? QW'(req_fifo_index) : '0;
   assign raddr        = AW'(32'(req_q) * DEPTH + 32'(head_ff[req_q]));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         q_ff        <= req_q;
         in_range_ff <= req_in_range;
         data_ff     <= DATA_WIDTH'(req_write_data);
         rdata_ff    <= store_mem[raddr];
      end
      if (mem_we) begin
         store_mem[waddr] <= data_ff;
      end
   end

   assign head_cur  = head_ff[q_ff];
   assign tail_cur  = tail_ff[q_ff];
   assign count_cur = count_ff[q_ff];
   assign lost_cur  = lost_ff[q_ff];
   assign waddr     = AW'(32'(q_ff) * DEPTH + 32'(tail_cur));
   assign update    = cmd.commit && in_range_ff;

   always_comb begin
      head_in   = head_cur;
      tail_in   = tail_cur;
      count_in  = count_cur;
      lost_in   = lost_cur;
      rd_value  = '0;
      status_in = ST_OK;
      mem_we    = 1'b0;
      unique case (op_ff)
         OP_READ: begin
            if (count_cur == '0) begin
               status_in = ST_EMPTY;
            end else begin
               rd_value = rdata_ff;
               head_in  = (head_cur == LAST_SLOT) ? '0 : head_cur + 1'b1;
               count_in = count_cur - 1'b1;
            end
         end
         OP_WRITE: begin
            mem_we = update;
            if (count_cur == LAST_SLOT) begin
               lost_in   = lost_cur + 1'b1;
               status_in = ST_LOST;
            end else begin
               tail_in  = (tail_cur == LAST_SLOT) ? '0 : tail_cur + 1'b1;
               count_in = count_cur + 1'b1;
            end
         end
         OP_INIT: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            lost_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         if (reset) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
            lost_ff[i]  <= '0;
         end else if (update && (QW'(i) == q_ff)) begin
            head_ff[i]  <= head_in;
            tail_ff[i]  <= tail_in;
            count_ff[i] <= count_in;
            lost_ff[i]  <= lost_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (in_range_ff) begin
            read_data_ff  <= WORD_WIDTH'(rd_value);
            status_ff     <= status_in;
            occ_ff        <= OCC_WIDTH'(count_in);
            lost_total_ff <= lost_in;
         end else begin
            read_data_ff  <= '0;
            status_ff     <= ST_OK;
            occ_ff        <= '0;
            lost_total_ff <= '0;
         end
      end
   end

   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = read_data_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occ_ff;
   assign rsp_lost_total = lost_total_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("commit while output register held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      update |-> (count_cur <= LAST_SLOT))
      else $error("queue count above capacity");

   a_lost_status: assert property (@(posedge clock) disable iff (reset)
      (update && op_ff == OP_WRITE && count_cur == LAST_SLOT)
      |=> (rsp_valid_ff && status_ff == ST_LOST))
      else $error("overwrite not reported as lost");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_EMPTY) |-> (read_data_ff == '0))
      else $error("empty read returned data");

endmodule

`default_nettype wire

>>> rtl/multi_fifo_lossy_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_fifo_lossy_queue_unit
// Several ring-buffer FIFOs with lossy overwrite on full and non-blocking read.
// ----------------------------------------------------------------------------
// A request is captured in the request registers on transfer; its result is written
// to the output register once that is free. The queue state is updated from the
//   registered store read of the accept cycle before a new request is accepted.
// A request is taken while the previous result still waits in the output register.
// Reset clears pointers, counts, lost counters and the controller; the entry
//   store is not cleared and is not needed to be, no clearing pass.
`default_nettype none

module multi_fifo_lossy_queue_unit
   import mflq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int NUM_QUEUES = 4,
   parameter int DATA_WIDTH = 32
) (
   input wire logic    clock,
   input wire logic    reset,
   mflq_req_if.sink    req_bus,
   mflq_rsp_if.source  rsp_bus
);

   ctrl_cmd_type    cmd;
   ctrl_status_type stat;
   logic            ready;

   mflq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mflq_dp #(
      .DEPTH      (DEPTH),
      .NUM_QUEUES (NUM_QUEUES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_bus.op),
      .req_fifo_index (req_bus.fifo_index),
      .req_write_data (req_bus.write_data),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_read_data  (rsp_bus.read_data),
      .rsp_status     (rsp_bus.status),
      .rsp_occupancy  (rsp_bus.occupancy),
      .rsp_lost_total (rsp_bus.lost_total)
   );

   assign req_bus.ready = ready;

endmodule

`default_nettype wire

>>> tb/multi_fifo_lossy_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// multi_fifo_lossy_queue_unit_tb
// Self-checking bench for the multi-FIFO lossy queue unit. Requests go through
// the req channel with random gaps and results are taken with random stalls on
// the rsp channel. A local model of the queues predicts every result, and each
// rsp transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module multi_fifo_lossy_queue_unit_tb
   import mflq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 16;
   localparam int NUM_QUEUES    = 4;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 100;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [WORD_WIDTH-1:0] read_data;
      status_type            status;
      logic [OCC_WIDTH-1:0]  occupancy;
      logic [LOST_WIDTH-1:0] lost_total;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mflq_req_if req_bus ();
   mflq_rsp_if rsp_bus ();

   multi_fifo_lossy_queue_unit #(
      .DEPTH      (DEPTH),
      .NUM_QUEUES (NUM_QUEUES),
      .DATA_WIDTH (WORD_WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // queue model
   logic [WORD_WIDTH-1:0] slot_word [NUM_QUEUES][DEPTH];
   int unsigned           head_ptr  [NUM_QUEUES];
   int unsigned           tail_ptr  [NUM_QUEUES];
   int unsigned           fill_count[NUM_QUEUES];
   logic [LOST_WIDTH-1:0] lost_cnt  [NUM_QUEUES];

   answer_type awaited_answers[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int idle_cycles   = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int read_ops      = 0;
   int empty_reads   = 0;
   int write_ops     = 0;
   int lost_writes   = 0;
   int init_ops      = 0;
   int unused_ops    = 0;

   function automatic answer_type apply_queue_op(input logic [OP_WIDTH-1:0] op,
                                                 input logic [INDEX_WIDTH-1:0] idx,
                                                 input logic [WORD_WIDTH-1:0] data);
      answer_type ans;
      int         q;
      ans.read_data  = '0;
      ans.status     = ST_OK;
      ans.occupancy  = '0;
      ans.lost_total = '0;
      q = int'(idx);
      if (q >= NUM_QUEUES) begin
         return ans;
      end
      case (op)
         OP_READ: begin
            read_ops++;
            if (fill_count[q] == 0) begin
               ans.status = ST_EMPTY;
               empty_reads++;
            end else begin
               ans.read_data = slot_word[q][head_ptr[q]];
               head_ptr[q]   = (head_ptr[q] + 1) % DEPTH;
               fill_count[q] = fill_count[q] - 1;
            end
         end
         OP_WRITE: begin
            write_ops++;
            slot_word[q][tail_ptr[q]] = data;
            if (fill_count[q] >= DEPTH - 1) begin
               // full: tail slot overwritten, pointers stay
               lost_cnt[q] = lost_cnt[q] + 1'b1;
               ans.status  = ST_LOST;
               lost_writes++;
            end else begin
               tail_ptr[q]   = (tail_ptr[q] + 1) % DEPTH;
               fill_count[q] = fill_count[q] + 1;
            end
         end
         OP_INIT: begin
            init_ops++;
            head_ptr[q]   = 0;
            tail_ptr[q]   = 0;
            fill_count[q] = 0;
            lost_cnt[q]   = '0;
         end
         default: begin
            unused_ops++;
         end
      endcase
      ans.occupancy  = OCC_WIDTH'(fill_count[q]);
      ans.lost_total = lost_cnt[q];
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_REPORTS) begin
         $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
      end
      error_count++;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_request(input logic [OP_WIDTH-1:0] op,
                               input logic [INDEX_WIDTH-1:0] idx,
                               input logic [WORD_WIDTH-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.op         = op;
      req_bus.fifo_index = idx;
      req_bus.write_data = data;
      do @(posedge clock); while (!req_bus.ready);
      awaited_answers.push_back(apply_queue_op(op, idx, data));
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // receiver: random stalls, or a forced hold-off counted down here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left     = hold_left - 1;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (awaited_answers.size() == 0) begin
            report_mismatch("unexpected transfer, read_data", rsp_bus.read_data, '0);
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_bus.read_data !== want.read_data)
               report_mismatch("read_data", rsp_bus.read_data, want.read_data);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.occupancy !== want.occupancy)
               report_mismatch("occupancy", rsp_bus.occupancy, want.occupancy);
            if (rsp_bus.lost_total !== want.lost_total)
               report_mismatch("lost_total", rsp_bus.lost_total, want.lost_total);
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_directed_cases();
      send_request(OP_READ, 2'd0, 32'h0);
      send_request(OP_WRITE, 2'd0, 32'hFFFF_FFFF);
      send_request(OP_WRITE, 2'd0, 32'h0000_0000);
      send_request(OP_UNUSED, 2'd0, 32'hA5A5_A5A5);
      send_request(OP_READ, 2'd0, 32'hFFFF_FFFF);
      send_request(OP_READ, 2'd0, 32'h0);
      send_request(OP_READ, 2'd0, 32'h0);
      // fill queue 3 to DEPTH-1, then one lossy write
      for (int i = 0; i < DEPTH; i++) begin
         send_request(OP_WRITE, 2'd3, 32'h1000_0000 + i);
      end
      send_request(OP_UNUSED, 2'd3, 32'h0);
      send_request(OP_READ, 2'd3, 32'h0);
      send_request(OP_INIT, 2'd3, 32'hFFFF_FFFF);
      send_request(OP_READ, 2'd3, 32'h0);
   endtask

   task automatic test_random_traffic(input int count);
      int sent;
      int len;
      int q;
      int kind;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         q    = $urandom_range(NUM_QUEUES - 1);
         len  = $urandom_range(20, 1);
         if (kind < 42) begin
            for (int i = 0; i < len; i++) begin
               send_request(OP_WRITE, INDEX_WIDTH'(q), pick_word());
            end
         end else if (kind < 78) begin
            for (int i = 0; i < len; i++) begin
               send_request(OP_READ, INDEX_WIDTH'(q), $urandom());
            end
         end else if (kind < 93) begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
               send_request(OP_WIDTH'($urandom_range(3)), INDEX_WIDTH'($urandom_range(3)),
                            pick_word());
            end
         end else if (kind < 97) begin
            len = 1;
            send_request(OP_INIT, INDEX_WIDTH'(q), $urandom());
         end else begin
            len = 1;
            send_request(OP_UNUSED, INDEX_WIDTH'(q), $urandom());
         end
         sent += len;
      end
   endtask

   // receiver holds off long enough for the unit to stall its req side
   task automatic test_backpressure();
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      for (int i = 0; i < 40; i++) begin
         send_request((i % 3 == 2) ? OP_READ : OP_WRITE, INDEX_WIDTH'($urandom_range(3)),
                      pick_word());
      end
   endtask

   // sender pauses until every result is back, then resumes
   task automatic test_drain_pause();
      for (int i = 0; i < 12; i++) send_request(OP_WRITE, 2'd1, pick_word());
      req_bus.valid = 1'b0;
      while (awaited_answers.size() != 0) @(negedge clock);
      for (int i = 0; i < 14; i++) send_request(OP_READ, 2'd1, 32'h0);
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_READ;
      req_bus.fifo_index = '0;
      req_bus.write_data = '0;
      rsp_bus.ready      = 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_ptr[q]   = 0;
         tail_ptr[q]   = 0;
         fill_count[q] = 0;
         lost_cnt[q]   = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 71;
      test_directed_cases();
      test_random_traffic(240);
      test_backpressure();

      send_idle_pct = 71;
      recv_idle_pct = 10;
      test_random_traffic(200);
      test_drain_pause();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(200);
      test_backpressure();

      req_bus.valid = 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d requests: %0d reads (%0d on empty), %0d writes (%0d lossy)",
               requests_sent, read_ops, empty_reads, write_ops, lost_writes);
      $display("  %0d inits, %0d unused ops, %0d results checked, %0d mismatches",
               init_ops, unused_ops, results_seen, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/mflq_pkg.sv
rtl/mflq_if.sv
rtl/mflq_ctrl.sv
rtl/mflq_dp.sv
rtl/multi_fifo_lossy_queue_unit.sv
tb/multi_fifo_lossy_queue_unit_tb.sv
